// File: rtl/sct_pkg.sv
// ----------------------------------------------------------------------------
// sct_pkg
// shared types and constants of the shell command tokenizer
// ----------------------------------------------------------------------------
package sct_pkg;

  // longest token holds MaxTokenLen - 1 characters
  localparam int MaxTokenLen = 1024;
  localparam int LenW        = $clog2(MaxTokenLen);
  localparam logic [LenW-1:0] TokLim = LenW'(MaxTokenLen - 1);

  // results one input byte can cause
  localparam int MaxRes = 3;
  localparam int CntW   = $clog2(MaxRes + 1);

  // result kinds
  localparam logic [2:0] KindWordCh   = 3'd0;
  localparam logic [2:0] KindQuotedCh = 3'd1;
  localparam logic [2:0] KindWordEnd  = 3'd2;
  localparam logic [2:0] KindQuoteEnd = 3'd3;
  localparam logic [2:0] KindLess     = 3'd4;
  localparam logic [2:0] KindGreater  = 3'd5;
  localparam logic [2:0] KindPipe     = 3'd6;
  localparam logic [2:0] KindUnterm   = 3'd7;

  // characters of interest
  localparam logic [7:0] ChBslash  = 8'h5C;
  localparam logic [7:0] ChQuote   = 8'h22;
  localparam logic [7:0] ChPipe    = 8'h7C;
  localparam logic [7:0] ChLess    = 8'h3C;
  localparam logic [7:0] ChGreater = 8'h3E;
  localparam logic [7:0] ChN       = 8'h6E;
  localparam logic [7:0] ChR       = 8'h72;
  localparam logic [7:0] ChT       = 8'h74;
  localparam logic [7:0] ChLf      = 8'h0A;
  localparam logic [7:0] ChCr      = 8'h0D;
  localparam logic [7:0] ChTab     = 8'h09;
  localparam logic [7:0] ChSpace   = 8'h20;
  localparam logic [7:0] ChVt      = 8'h0B;

  typedef struct packed {
    logic [7:0] ch;
    logic       final_req;
  } in_t;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] text_byte;
    logic       bad_escape;
    logic       truncated;
    logic       run_end;
  } out_t;

  typedef struct packed {
    logic            inside_quotes;
    logic            escape_pending;
    logic [LenW-1:0] token_length;
  } lex_state_t;

  // results of one byte, in order, with their count
  typedef struct packed {
    logic [CntW-1:0]        count;
    out_t [MaxRes-1:0]      res;
  } batch_t;

endpackage

// File: rtl/sct_step.sv
// ----------------------------------------------------------------------------
// sct_step
// next-state and result logic for one command-line byte
// ----------------------------------------------------------------------------
module sct_step (
  input  sct_pkg::lex_state_t st_i,
  input  sct_pkg::in_t        item_i,
  output sct_pkg::lex_state_t st_o,
  output sct_pkg::batch_t     batch_o
);

  function automatic sct_pkg::out_t mk(input logic [2:0] kind, input logic [7:0] tb,
                                       input logic bad, input logic trunc);
    sct_pkg::out_t r;
    r.kind       = kind;
    r.text_byte  = tb;
    r.bad_escape = bad;
    r.truncated  = trunc;
    r.run_end    = 1'b0;
    return r;
  endfunction

  logic [sct_pkg::LenW-1:0] len;
  logic                     q;
  logic                     esc;
  logic [sct_pkg::CntW-1:0] n;
  logic                     full;
  logic [1:0]               nch;
  logic [7:0]               c0;
  logic [7:0]               c1;
  logic                     bad;
  logic                     pre_end;
  logic [2:0]               pre_kind;
  logic                     op;
  logic [2:0]               op_kind;
  logic [7:0]               ch;
  sct_pkg::out_t [sct_pkg::MaxRes-1:0] res;

  always_comb begin
    ch       = item_i.ch;
    len      = st_i.token_length;
    q        = st_i.inside_quotes;
    esc      = st_i.escape_pending;
    n        = '0;
    res      = '0;
    full     = 1'b0;
    nch      = 2'd0;
    c0       = 8'h00;
    c1       = 8'h00;
    bad      = 1'b0;
    pre_end  = 1'b0;
    pre_kind = sct_pkg::KindWordEnd;
    op       = 1'b0;
    op_kind  = sct_pkg::KindPipe;

    // classify the byte
    if (esc) begin
      esc = 1'b0;
      case (ch)
        sct_pkg::ChN: begin
          nch = 2'd1;
          c0  = sct_pkg::ChLf;
        end
        sct_pkg::ChR: begin
          nch = 2'd1;
          c0  = sct_pkg::ChCr;
        end
        sct_pkg::ChT: begin
          nch = 2'd1;
          c0  = sct_pkg::ChTab;
        end
        default: begin
          // backslash kept in front of the escaped byte
          nch = 2'd2;
          c0  = sct_pkg::ChBslash;
          c1  = ch;
          bad = !(ch inside {sct_pkg::ChLess, sct_pkg::ChGreater, sct_pkg::ChPipe});
        end
      endcase
    end else if (ch == sct_pkg::ChBslash) begin
      esc = 1'b1;
    end else if (ch == sct_pkg::ChQuote) begin
      pre_end  = 1'b1;
      pre_kind = q ? sct_pkg::KindQuoteEnd : sct_pkg::KindWordEnd;
      q        = !q;
    end else if (!q && (ch inside {sct_pkg::ChLess, sct_pkg::ChGreater, sct_pkg::ChPipe})) begin
      pre_end = 1'b1;
      op      = 1'b1;
      if (ch == sct_pkg::ChLess) begin
        op_kind = sct_pkg::KindLess;
      end else if (ch == sct_pkg::ChGreater) begin
        op_kind = sct_pkg::KindGreater;
      end else begin
        op_kind = sct_pkg::KindPipe;
      end
    end else if (!q && (ch inside {sct_pkg::ChSpace, [sct_pkg::ChTab:sct_pkg::ChCr]})) begin
      pre_end = 1'b1;
    end else begin
      nch = 2'd1;
      c0  = ch;
    end

    // end marker for a pending token
    if (pre_end && (len != '0)) begin
      res[n] = mk(pre_kind, 8'h00, 1'b0, 1'b0);
      n      = n + 1'b1;
      len    = '0;
    end

    if (op) begin
      res[n] = mk(op_kind, ch, 1'b0, 1'b0);
      n      = n + 1'b1;
    end

    // token characters, flagged truncated and not counted once the token is full
    if (nch != 2'd0) begin
      full   = (len >= sct_pkg::TokLim);
      res[n] = mk(q ? sct_pkg::KindQuotedCh : sct_pkg::KindWordCh, c0, bad, full);
      n      = n + 1'b1;
      if (!full) begin
        len = len + 1'b1;
      end
    end
    if (nch == 2'd2) begin
      full   = (len >= sct_pkg::TokLim);
      res[n] = mk(q ? sct_pkg::KindQuotedCh : sct_pkg::KindWordCh, c1, bad, full);
      n      = n + 1'b1;
      if (!full) begin
        len = len + 1'b1;
      end
    end

    // end-of-input flush
    if (item_i.final_req) begin
      if (len != '0) begin
        res[n] = mk(q ? sct_pkg::KindUnterm : sct_pkg::KindWordEnd, 8'h00, 1'b0, 1'b0);
        n      = n + 1'b1;
      end
      len = '0;
      q   = 1'b0;
      esc = 1'b0;
    end

    st_o.inside_quotes  = q;
    st_o.escape_pending = esc;
    st_o.token_length   = len;
    batch_o.count       = n;
    batch_o.res         = res;
  end

endmodule

// File: rtl/sct_outq.sv
// ----------------------------------------------------------------------------
// sct_outq
// result register bank: holds the results of one byte, hands them out in order
// ----------------------------------------------------------------------------
module sct_outq (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            load,
  input  sct_pkg::batch_t batch,
  output logic            can_load,
  output logic            out_valid,
  input  logic            out_ready,
  output sct_pkg::out_t   out_data
);

  sct_pkg::out_t [sct_pkg::MaxRes-1:0] buf_r;
  sct_pkg::out_t [sct_pkg::MaxRes-1:0] buf_nxt;
  logic [sct_pkg::CntW-1:0]           cnt_r;
  logic [sct_pkg::CntW-1:0]           cnt_nxt;
  logic                               pop;

  assign out_valid = (cnt_r != '0);
  assign pop       = out_valid && out_ready;
  // new batch may enter once the last held result leaves
  assign can_load  = (cnt_r == '0) || ((cnt_r == sct_pkg::CntW'(1)) && out_ready);

  always_comb begin
    out_data         = buf_r[0];
    out_data.run_end = (cnt_r == sct_pkg::CntW'(1));
  end

  always_comb begin
    buf_nxt = buf_r;
    cnt_nxt = cnt_r;
    if (load) begin
      buf_nxt = batch.res;
      cnt_nxt = batch.count;
    end else if (pop) begin
      for (int i = 0; i < sct_pkg::MaxRes - 1; i++) begin
        buf_nxt[i] = buf_r[i+1];
      end
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    buf_r <= buf_nxt;
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= sct_pkg::CntW'(sct_pkg::MaxRes))
    else $error("result count out of range");

  a_load_safe: assert property (@(posedge clk) disable iff (!rst_n)
    load |-> ((cnt_r == '0) || ((cnt_r == sct_pkg::CntW'(1)) && out_ready)))
    else $error("batch loaded over undelivered results");

  a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
    (load && (batch.count != '0)) |=> out_valid)
    else $error("loaded results not presented");

  a_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && !load && (cnt_r == sct_pkg::CntW'(1))) |=> !out_valid)
    else $error("result repeated after last one taken");

endmodule

// File: rtl/shell_command_tokenizer_unit.sv
// ----------------------------------------------------------------------------
// shell_command_tokenizer_unit
// byte-serial shell command-line lexer with quotes, escapes and operators
// ----------------------------------------------------------------------------
// Takes one command-line byte per transaction and returns 0 to 3 token events
// per byte, the last one flagged by run_end. A byte is processed in the cycle
// it is accepted and its results sit in the result registers the next cycle.
// A byte giving zero or one result is taken every cycle while the consumer
// keeps up; a byte giving two or three results holds off the next byte until
// its last result is taken, since the result registers hand out one event a cycle.
// There is no setup: after reset the lexer is outside quotes, with no escape
// pending and an empty token, and it returns there after each final byte.
// ----------------------------------------------------------------------------
module shell_command_tokenizer_unit (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  sct_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output sct_pkg::out_t out_data
);

  // lexer state: quote flag, pending backslash, characters in current token
  sct_pkg::lex_state_t st_r;
  sct_pkg::lex_state_t st_nxt;
  sct_pkg::batch_t     batch;
  logic                in_fire;
  logic                can_load;

  // byte taken only when its results can go straight into the result bank
  assign in_ready = can_load;
  assign in_fire  = in_valid && in_ready;

  // combinational work for the byte on the input port
  sct_step u_step (
    .st_i    (st_r),
    .item_i  (in_data),
    .st_o    (st_nxt),
    .batch_o (batch)
  );

  // result bank, drained one event per output transaction
  sct_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (in_fire),
    .batch     (batch),
    .can_load  (can_load),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // state advances only with an accepted byte
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '0;
    end else if (in_fire) begin
      st_r <= st_nxt;
    end
  end

  a_len_limit: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.token_length <= sct_pkg::TokLim)
    else $error("token length beyond limit");

  a_final_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_data.final_req) |=> (st_r == '0))
    else $error("state not cleared after final byte");

  a_hold_state: assert property (@(posedge clk) disable iff (!rst_n)
    !in_fire |=> $stable(st_r))
    else $error("state changed without a byte");

endmodule
